// ===== hw/rtl/shadow_table_crc_commit_assert.svh =====
// Assertion macros for the shadow table commit block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef SHADOW_TABLE_CRC_COMMIT_ASSERT_SVH
`define SHADOW_TABLE_CRC_COMMIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/stcc_pkg.sv =====
// Shared types, codes and the CRC-32 byte step for the shadow table commit block.
// No dependencies.
package stcc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_COMMIT = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_TOO_MANY       = 3'd1,
    ST_NOT_BUILDING   = 3'd2,
    ST_INDEX_RANGE    = 3'd3,
    ST_COUNT_MISMATCH = 3'd4,
    ST_CRC_MISMATCH   = 3'd5,
    ST_READ_RANGE     = 3'd6
  } status_e;

  // Control sequencer of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COMMIT
  } ctrl_e;

  // CRC walk sequencer.
  typedef enum logic [0:0] {
    W_IDLE,
    W_BYTES
  } walk_e;

  typedef struct packed {
    logic       start;
    logic       bank;
    logic [7:0] count;
  } crc_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] crc;
  } crc_rsp_t;

  typedef struct packed {
    logic        accepted;
    status_e     status;
    logic [31:0] read_word;
    logic [7:0]  active_count;
    logic        active_bank;
    logic        upload_open;
  } res_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/stcc_if.sv =====
// Valid/ready channel interfaces: command in, response out.
// No dependencies.
interface stcc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  entry_count;
  logic [7:0]  entry_index;
  logic [5:0]  word_index;
  logic [31:0] word_data;
  logic        entry_done;
  logic [31:0] expected_crc;

  modport source (output valid, operation, entry_count, entry_index, word_index,
                  word_data, entry_done, expected_crc, input ready);
  modport sink   (input valid, operation, entry_count, entry_index, word_index,
                  word_data, entry_done, expected_crc, output ready);
endinterface

interface stcc_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  status;
  logic [31:0] read_word;
  logic [7:0]  active_count;
  logic        active_bank;
  logic        upload_open;

  modport source (output valid, accepted, status, read_word, active_count,
                  active_bank, upload_open, input ready);
  modport sink   (input valid, accepted, status, read_word, active_count,
                  active_bank, upload_open, output ready);
endinterface

// ===== hw/rtl/stcc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module stcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/stcc_crc_walk.sv =====
// Walks the shadow bank word by word and folds it into a CRC-32, one byte a cycle.
// Depends on stcc_pkg; drives the read port of stcc_ram through the top level.
module stcc_crc_walk #(
  parameter int MAX_ENTRIES     = 128,
  parameter int WORDS_PER_ENTRY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stcc_pkg::crc_req_t req_i,
  input  logic [31:0]       rdata_i,
  output logic              rd_en_o,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1) +
                ((WORDS_PER_ENTRY > 1) ? $clog2(WORDS_PER_ENTRY) : 1):0] rd_addr_o,
  output stcc_pkg::crc_rsp_t rsp_o
);
  import stcc_pkg::*;

  localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WORD_W  = (WORDS_PER_ENTRY > 1) ? $clog2(WORDS_PER_ENTRY) : 1;

  walk_e              state_q, state_d;
  logic               bank_q, bank_d;
  logic [7:0]         count_q, count_d;
  logic [ENTRY_W-1:0] entry_q, entry_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [1:0]         byte_q, byte_d;
  logic [31:0]        acc_q, acc_d;
  logic               done_q, done_d;

  logic               last_word, last_entry, last_byte;
  logic [ENTRY_W-1:0] next_entry;
  logic [WORD_W-1:0]  next_word;

  assign last_word  = (word_q == WORD_W'(WORDS_PER_ENTRY - 1));
  assign last_entry = ((8'(entry_q) + 8'd1) == count_q);
  assign last_byte  = (byte_q == 2'd3);
  assign next_word  = last_word ? '0 : word_q + WORD_W'(1);
  assign next_entry = last_word ? entry_q + ENTRY_W'(1) : entry_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE:  if (req_i.start) state_d = W_BYTES;
      W_BYTES: if (last_byte && last_word && last_entry) state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    bank_d    = bank_q;
    count_d   = count_q;
    entry_d   = entry_q;
    word_d    = word_q;
    byte_d    = byte_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = {bank_q, next_entry, next_word};
    unique case (state_q)
      W_IDLE: begin
        if (req_i.start) begin
          bank_d    = req_i.bank;
          count_d   = req_i.count;
          entry_d   = '0;
          word_d    = '0;
          byte_d    = 2'd0;
          acc_d     = CRC_ONES;
          rd_en_o   = 1'b1;
          rd_addr_o = {req_i.bank, {ENTRY_W{1'b0}}, {WORD_W{1'b0}}};
        end
      end
      W_BYTES: begin
        acc_d  = crc_byte(acc_q, rdata_i[8*byte_q +: 8]);
        byte_d = byte_q + 2'd1;
        if (last_byte) begin
          if (last_word && last_entry) begin
            done_d = 1'b1;
          end else begin
            // fetch the next word so its data lands for byte 0
            entry_d = next_entry;
            word_d  = next_word;
            rd_en_o = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
      acc_q   <= CRC_ONES;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q  <= bank_d;
    count_q <= count_d;
    entry_q <= entry_d;
    word_q  <= word_d;
    byte_q  <= byte_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.crc  = acc_q ^ CRC_ONES;

endmodule

// ===== hw/rtl/shadow_table_crc_commit.sv =====
// Top level of the double-buffered rule table with CRC-checked commit.
// Depends on stcc_pkg, stcc_if, stcc_ram and stcc_crc_walk.
//
//   channel  | dir | transaction carries
//   ---------+-----+---------------------------------------------------------------
//   cmd_i    | in  | operation, entry_count, entry_index, word_index, word_data, ...
//   rsp_o    | out | accepted, status, read_word, active_count, active_bank, upload_open
//
// Begin, write, empty commit and a commit failing before the walk load the response register
// on acceptance; a read loads it from S_READ with the registered RAM word. A commit that runs
// the CRC walk loads it when the byte-serial walk over the single RAM read port is done.
// One command at a time; cmd_i.ready drops while a read or a commit walk is in flight
// and while a response sits unclaimed in the output register.
// Reset clears control state only; the entry store needs no clearing pass.
module shadow_table_crc_commit #(
  parameter int MAX_ENTRIES     = 128,
  parameter int WORDS_PER_ENTRY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stcc_cmd_if.sink   cmd_i,
  stcc_rsp_if.source rsp_o
);
  import stcc_pkg::*;

  localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WORD_W  = (WORDS_PER_ENTRY > 1) ? $clog2(WORDS_PER_ENTRY) : 1;
  localparam int ADDR_W  = 1 + ENTRY_W + WORD_W;

  ctrl_e       state_q, state_d;
  logic        live_q, live_d;
  logic        building_q, building_d;
  logic        shadow_q, shadow_d;
  logic [7:0]  expected_q, expected_d;
  logic [15:0] filled_q, filled_d;
  logic [7:0]  cnt_q [2];
  logic [7:0]  cnt_d [2];
  logic [31:0] pend_crc_q, pend_crc_d;
  logic        rd_ok_q, rd_ok_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;

  status_e     res_status;
  logic        res_load;
  logic [31:0] res_word;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, cmd_raddr, walk_addr;
  logic [31:0]       ram_rdata;
  logic              walk_rd_en;
  crc_req_t          crc_req;
  crc_rsp_t          crc_rsp;

  op_e  op;
  logic cmd_acc, count_over, write_ok, count_match, read_ok, commit_walk;

  assign op          = op_e'(cmd_i.operation);
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign count_over  = cmd_i.entry_count > 8'(MAX_ENTRIES);
  assign write_ok    = (cmd_i.entry_index < expected_q) &&
                       ({1'b0, cmd_i.word_index} < 7'(WORDS_PER_ENTRY));
  assign count_match = (cmd_i.entry_count == expected_q) &&
                       (filled_q == {8'd0, cmd_i.entry_count});
  assign read_ok     = (cmd_i.entry_index < cnt_q[live_q]) &&
                       ({1'b0, cmd_i.word_index} < 7'(WORDS_PER_ENTRY));
  assign commit_walk = cmd_acc && (op == OP_COMMIT) && building_q && count_match &&
                       (cmd_i.entry_count != 8'd0);
  assign cmd_raddr   = {live_q, cmd_i.entry_index[ENTRY_W-1:0], cmd_i.word_index[WORD_W-1:0]};

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_acc && (op == OP_READ)) begin
          state_d = S_READ;
        end else if (commit_walk) begin
          state_d = S_COMMIT;
        end
      end
      S_READ:   state_d = S_IDLE;
      S_COMMIT: if (crc_rsp.done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath / outputs
  always_comb begin
    live_d       = live_q;
    building_d   = building_q;
    shadow_d     = shadow_q;
    expected_d   = expected_q;
    filled_d     = filled_q;
    cnt_d        = cnt_q;
    pend_crc_d   = pend_crc_q;
    rd_ok_d      = rd_ok_q;
    ram_we       = 1'b0;
    ram_waddr    = {shadow_q, cmd_i.entry_index[ENTRY_W-1:0], cmd_i.word_index[WORD_W-1:0]};
    crc_req      = '{start: 1'b0, bank: shadow_q, count: cmd_i.entry_count};
    res_status   = ST_OK;
    res_load     = 1'b0;
    res_word     = 32'd0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          unique case (op)
            OP_BEGIN: begin
              res_load = 1'b1;
              if (count_over) begin
                res_status = ST_TOO_MANY;
              end else begin
                shadow_d   = ~live_q;
                expected_d = cmd_i.entry_count;
                filled_d   = 16'd0;
                building_d = 1'b1;
              end
            end
            OP_WRITE: begin
              res_load = 1'b1;
              if (!building_q) begin
                res_status = ST_NOT_BUILDING;
              end else if (!write_ok) begin
                res_status = ST_INDEX_RANGE;
              end else begin
                ram_we = 1'b1;
                if (cmd_i.entry_done && (filled_q != '1)) begin
                  filled_d = filled_q + 16'd1;
                end
              end
            end
            OP_COMMIT: begin
              if (!building_q) begin
                res_load   = 1'b1;
                res_status = ST_NOT_BUILDING;
              end else begin
                building_d = 1'b0;
                if (!count_match) begin
                  res_load   = 1'b1;
                  res_status = ST_COUNT_MISMATCH;
                end else if (cmd_i.entry_count == 8'd0) begin
                  // empty table: CRC of nothing is zero
                  res_load = 1'b1;
                  if (cmd_i.expected_crc != 32'd0) begin
                    res_status = ST_CRC_MISMATCH;
                  end else begin
                    cnt_d[shadow_q] = cmd_i.entry_count;
                    live_d          = shadow_q;
                  end
                end else begin
                  crc_req.start = 1'b1;
                  pend_crc_d    = cmd_i.expected_crc;
                end
              end
            end
            OP_READ: begin
              rd_ok_d = read_ok;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_load   = 1'b1;
        res_status = rd_ok_q ? ST_OK : ST_READ_RANGE;
        res_word   = rd_ok_q ? ram_rdata : 32'd0;
      end
      S_COMMIT: begin
        if (crc_rsp.done) begin
          res_load = 1'b1;
          if (crc_rsp.crc != pend_crc_q) begin
            res_status = ST_CRC_MISMATCH;
          end else begin
            // the expected count equals the shadow count once the walk starts
            cnt_d[shadow_q] = expected_q;
            live_d          = shadow_q;
          end
        end
      end
      default: ;
    endcase

    out_valid_d = out_valid_q && !rsp_o.ready;
    res_d       = res_q;
    if (res_load) begin
      out_valid_d        = 1'b1;
      res_d.accepted     = (res_status == ST_OK);
      res_d.status       = res_status;
      res_d.read_word    = res_word;
      res_d.active_count = cnt_d[live_d];
      res_d.active_bank  = live_d;
      res_d.upload_open  = building_d;
    end
  end

  // Reads of the command and of the walk never overlap: the walk runs with cmd_i stalled.
  assign ram_re    = walk_rd_en || (cmd_acc && (op == OP_READ));
  assign ram_raddr = walk_rd_en ? walk_addr : cmd_raddr;

  stcc_ram #(
    .WIDTH (32),
    .DEPTH (2 ** ADDR_W)
  ) u_stcc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.word_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stcc_crc_walk #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .WORDS_PER_ENTRY (WORDS_PER_ENTRY)
  ) u_stcc_crc_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (crc_req),
    .rdata_i   (ram_rdata),
    .rd_en_o   (walk_rd_en),
    .rd_addr_o (walk_addr),
    .rsp_o     (crc_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= 1'b0;
      building_q  <= 1'b0;
      shadow_q    <= 1'b1;
      expected_q  <= 8'd0;
      filled_q    <= 16'd0;
      cnt_q[0]    <= 8'd0;
      cnt_q[1]    <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      building_q  <= building_d;
      shadow_q    <= shadow_d;
      expected_q  <= expected_d;
      filled_q    <= filled_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_crc_q <= pend_crc_d;
    rd_ok_q    <= rd_ok_d;
    res_q      <= res_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.accepted     = res_q.accepted;
  assign rsp_o.status       = res_q.status;
  assign rsp_o.read_word    = res_q.read_word;
  assign rsp_o.active_count = res_q.active_count;
  assign rsp_o.active_bank  = res_q.active_bank;
  assign rsp_o.upload_open  = res_q.upload_open;

endmodule

// ===== hw/rtl/stcc_checker.sv =====
// Port-level checks on the response channel of the shadow table commit block.
// Depends on stcc_pkg and shadow_table_crc_commit_assert.svh; bound to the top level.
`include "shadow_table_crc_commit_assert.svh"

module stcc_checker #(
  parameter int MAX_ENTRIES = 128
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_accepted_i,
  input logic [2:0]  rsp_status_i,
  input logic [31:0] rsp_read_word_i,
  input logic [7:0]  rsp_active_count_i,
  input logic        rsp_upload_open_i
);
  import stcc_pkg::*;

  // a stalled response keeps its status
  `STCC_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i), "response changed while stalled")

  `STCC_ASSERT_SAME(a_accept_ok, rsp_valid_i, rsp_accepted_i == (rsp_status_i == ST_OK), "accepted disagrees with status")

  `STCC_ASSERT_SAME(a_word_on_ok, rsp_valid_i && (rsp_read_word_i != 32'd0), rsp_accepted_i, "read word on a rejected transaction")

  // a commit that fails the count or CRC check closes the upload
  `STCC_ASSERT_SAME(a_commit_closes, rsp_valid_i && ((rsp_status_i == ST_COUNT_MISMATCH) || (rsp_status_i == ST_CRC_MISMATCH)), !rsp_upload_open_i, "upload still open after failed commit")

  `STCC_ASSERT_SAME(a_count_cap, rsp_valid_i, rsp_active_count_i <= 8'(MAX_ENTRIES), "active count above capacity")

endmodule

bind shadow_table_crc_commit stcc_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_stcc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_accepted_i     (rsp_o.accepted),
  .rsp_status_i       (rsp_o.status),
  .rsp_read_word_i    (rsp_o.read_word),
  .rsp_active_count_i (rsp_o.active_count),
  .rsp_upload_open_i  (rsp_o.upload_open)
);
